// ===== hw/rtl/move_to_front_key_cache_defines.svh =====
// Assertion macros shared by the move-to-front key cache RTL.
// Each macro expects signals named clk and arst_n in the using module.
`ifndef MOVE_TO_FRONT_KEY_CACHE_DEFINES_SVH
`define MOVE_TO_FRONT_KEY_CACHE_DEFINES_SVH

// A property that must hold at every clock edge out of reset.
`define MTFKC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that, when true, requires a consequence in the next cycle.
`define MTFKC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== hw/rtl/mtfkc_pkg.sv =====
// Shared types and constants for the move-to-front key cache.
// No dependencies; used by the interfaces, the cell and the top level.
package mtfkc_pkg;

	localparam int CMD_W     = 2;
	localparam int SET_W     = 8;
	localparam int PAY_W     = 16;
	localparam int IDX_W     = 3;
	localparam int CNT_W     = 4;
	localparam logic [CNT_W-1:0] CAP_RESET = 4'd8;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOOKUP  = 2'd0,
		CMD_INSERT  = 2'd1,
		CMD_DISCARD = 2'd2
	} cmd_e;

	typedef struct packed {
		logic [SET_W-1:0] key_set;
		logic             key_bold;
		logic [PAY_W-1:0] payload;
	} entry_t;

	typedef struct packed {
		logic load_front;
		logic load_left;
		logic load_right;
	} cell_ctrl_t;

endpackage

// ===== hw/rtl/mtfkc_if.sv =====
// Valid/ready channel interfaces for the request and response items.
// Depends on mtfkc_pkg for field widths.
interface mtfkc_req_if;
	import mtfkc_pkg::*;
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic [SET_W-1:0] key_set;
	logic             key_bold;
	logic [PAY_W-1:0] entry_payload;
	logic [IDX_W-1:0] entry_index;

	modport source (output valid, command, key_set, key_bold, entry_payload, entry_index,
		input ready);
	modport sink (input valid, command, key_set, key_bold, entry_payload, entry_index,
		output ready);
endinterface

interface mtfkc_rsp_if;
	import mtfkc_pkg::*;
	logic             valid;
	logic             ready;
	logic             hit;
	logic [IDX_W-1:0] hit_index;
	logic [PAY_W-1:0] hit_payload;
	logic             evicted;
	logic [PAY_W-1:0] evicted_payload;
	logic [CNT_W-1:0] entry_total;

	modport source (output valid, hit, hit_index, hit_payload, evicted, evicted_payload,
		entry_total, input ready);
	modport sink (input valid, hit, hit_index, hit_payload, evicted, evicted_payload,
		entry_total, output ready);
endinterface

// ===== hw/rtl/mtfkc_cell.sv =====
// One position of the move-to-front list: holds an entry and compares its key.
// Depends on mtfkc_pkg; loads from the front, the left or the right neighbor.
module mtfkc_cell (
	input  logic                         clk,
	input  mtfkc_pkg::cell_ctrl_t        ctrl,
	input  mtfkc_pkg::entry_t            front_entry,
	input  mtfkc_pkg::entry_t            left_entry,
	input  mtfkc_pkg::entry_t            right_entry,
	input  logic [mtfkc_pkg::SET_W-1:0]  search_set,
	input  logic                         search_bold,
	output mtfkc_pkg::entry_t            entry,
	output logic                         match
);
	import mtfkc_pkg::*;

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.load_front) begin
			entry_q <= front_entry;
		end else if (ctrl.load_left) begin
			entry_q <= left_entry;
		end else if (ctrl.load_right) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;
	assign match = (entry_q.key_set == search_set) && (entry_q.key_bold == search_bold);

endmodule

// ===== hw/rtl/move_to_front_key_cache.sv =====
// Top level of the move-to-front key cache: a chain of entry cells plus control.
// Depends on mtfkc_pkg, mtfkc_if, mtfkc_cell and the assertion macro header.
//
// Channel   Dir  Handshake             Item contents
// req       in   valid/ready           command, key, payload, index
// rsp       out  valid/ready           hit, eviction, index, payloads, entry total
// cfg       in   cfg_we, no stall      capacity
//
// Each item first compares all cells and registers the move plan; once the response
// register is free or draining, it shifts the cell chain and loads the response register.
// The next item is accepted while a response still waits, then held until it drains.
// Reset clears the entry count and sets the capacity to eight; entries need no clearing.
`include "move_to_front_key_cache_defines.svh"

module move_to_front_key_cache #(
	parameter int MAX_ENTRIES = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	mtfkc_req_if.sink                   req,
	mtfkc_rsp_if.source                 rsp,
	input  logic                        cfg_we,
	input  logic [mtfkc_pkg::CNT_W-1:0] cfg_wdata
);
	import mtfkc_pkg::*;

	localparam int JW = $clog2(MAX_ENTRIES + 1);
	localparam int VW = (JW > CNT_W) ? JW : CNT_W;

	logic [CNT_W-1:0]       cap_q;
	logic [CNT_W-1:0]       count_q;
	logic                   pend_s1;
	logic                   apply;
	logic                   accept;

	entry_t                 cell_entry [MAX_ENTRIES];
	cell_ctrl_t             cell_ctrl  [MAX_ENTRIES];
	cell_ctrl_t             ctrl_nxt   [MAX_ENTRIES];
	cell_ctrl_t             ctrl_s1    [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] cell_match;
	logic [MAX_ENTRIES-1:0] valid_vec;
	logic [MAX_ENTRIES-1:0] match_vec;
	logic [MAX_ENTRIES-1:0] first_vec;
	logic [MAX_ENTRIES-1:0] rd_sel;
	logic [MAX_ENTRIES-1:0] left_mask;
	logic [MAX_ENTRIES-1:0] right_mask;
	logic [PAY_W-1:0]       rd_pay;
	logic [IDX_W-1:0]       first_idx;
	logic [CNT_W-1:0]       eff_cap;
	logic                   load_front;
	entry_t                 front_nxt;
	entry_t                 front_s1;
	entry_t                 empty_entry;

	logic                   hit_nxt, evicted_nxt;
	logic [IDX_W-1:0]       hit_index_nxt;
	logic [PAY_W-1:0]       hit_payload_nxt, evicted_payload_nxt;
	logic [CNT_W-1:0]       count_nxt;

	logic                   hit_s1, evicted_s1;
	logic [IDX_W-1:0]       hit_index_s1;
	logic [PAY_W-1:0]       hit_payload_s1, evicted_payload_s1;
	logic [CNT_W-1:0]       count_s1;
	cmd_e                   cmd_s1;

	logic                   out_valid_q;
	logic                   hit_q, evicted_q;
	logic [IDX_W-1:0]       hit_index_q;
	logic [PAY_W-1:0]       hit_payload_q, evicted_payload_q;

	assign accept      = req.valid && req.ready;
	assign req.ready   = !pend_s1;
	assign apply       = pend_s1 && (!out_valid_q || rsp.ready);
	assign empty_entry = '0;

	// Cell chain.
	for (genvar j = 0; j < MAX_ENTRIES; j++) begin : g_cell
		entry_t left_in;
		entry_t right_in;
		if (j == 0) begin : g_first
			assign left_in = empty_entry;
		end else begin : g_mid_l
			assign left_in = cell_entry[j-1];
		end
		if (j == MAX_ENTRIES - 1) begin : g_last
			assign right_in = empty_entry;
		end else begin : g_mid_r
			assign right_in = cell_entry[j+1];
		end
		assign cell_ctrl[j] = apply ? ctrl_s1[j] : cell_ctrl_t'('0);

		mtfkc_cell u_cell (
			.clk         (clk),
			.ctrl        (cell_ctrl[j]),
			.front_entry (front_s1),
			.left_entry  (left_in),
			.right_entry (right_in),
			.search_set  (req.key_set),
			.search_bold (req.key_bold),
			.entry       (cell_entry[j]),
			.match       (cell_match[j])
		);
	end

	// Compare stage: plan the move and read the payload that the item reports.
	always_comb begin
		for (int j = 0; j < MAX_ENTRIES; j++) begin
			valid_vec[j] = VW'(j) < VW'(count_q);
		end
		match_vec = cell_match & valid_vec;
		first_vec = match_vec & ((~match_vec) + {{(MAX_ENTRIES-1){1'b0}}, 1'b1});
		first_idx = '0;
		for (int j = 0; j < MAX_ENTRIES; j++) begin
			if (first_vec[j]) begin
				first_idx = first_idx | IDX_W'(j);
			end
		end

		if (cap_q == '0) begin
			eff_cap = CNT_W'(1);
		end else if (VW'(cap_q) > VW'(MAX_ENTRIES)) begin
			eff_cap = CNT_W'(MAX_ENTRIES);
		end else begin
			eff_cap = cap_q;
		end

		rd_sel              = '0;
		left_mask           = '0;
		right_mask          = '0;
		load_front          = 1'b0;
		front_nxt.key_set   = req.key_set;
		front_nxt.key_bold  = req.key_bold;
		front_nxt.payload   = req.entry_payload;
		hit_nxt             = 1'b0;
		hit_index_nxt       = '0;
		evicted_nxt         = 1'b0;
		count_nxt           = count_q;

		case (cmd_e'(req.command))
			CMD_LOOKUP: begin
				if (|match_vec) begin
					hit_nxt       = 1'b1;
					hit_index_nxt = first_idx;
					rd_sel        = first_vec;
					left_mask     = (first_vec - {{(MAX_ENTRIES-1){1'b0}}, 1'b1}) << 1;
					load_front    = 1'b1;
				end
			end
			CMD_INSERT: begin
				load_front = 1'b1;
				left_mask  = ~{{(MAX_ENTRIES-1){1'b0}}, 1'b1};
				if (count_q >= eff_cap) begin
					evicted_nxt = 1'b1;
					count_nxt   = eff_cap;
					for (int j = 0; j < MAX_ENTRIES; j++) begin
						rd_sel[j] = VW'(j) == (VW'(count_q) - VW'(1));
					end
				end else begin
					count_nxt = count_q + CNT_W'(1);
				end
			end
			CMD_DISCARD: begin
				if (VW'(req.entry_index) < VW'(count_q)) begin
					evicted_nxt = 1'b1;
					count_nxt   = count_q - CNT_W'(1);
					for (int j = 0; j < MAX_ENTRIES; j++) begin
						rd_sel[j]     = VW'(j) == VW'(req.entry_index);
						right_mask[j] = (VW'(j) >= VW'(req.entry_index))
							&& (j < MAX_ENTRIES - 1);
					end
				end
			end
			default: begin
			end
		endcase

		rd_pay = '0;
		for (int j = 0; j < MAX_ENTRIES; j++) begin
			if (rd_sel[j]) begin
				rd_pay = rd_pay | cell_entry[j].payload;
			end
		end
		if (hit_nxt) begin
			front_nxt.payload = rd_pay;
		end
		hit_payload_nxt     = hit_nxt ? rd_pay : '0;
		evicted_payload_nxt = evicted_nxt ? rd_pay : '0;

		for (int j = 0; j < MAX_ENTRIES; j++) begin
			ctrl_nxt[j].load_front = load_front && (j == 0);
			ctrl_nxt[j].load_left  = left_mask[j];
			ctrl_nxt[j].load_right = right_mask[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (accept) begin
			pend_s1 <= 1'b1;
		end else if (apply) begin
			pend_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_s1            <= ctrl_nxt;
			front_s1           <= front_nxt;
			hit_s1             <= hit_nxt;
			hit_index_s1       <= hit_index_nxt;
			hit_payload_s1     <= hit_payload_nxt;
			evicted_s1         <= evicted_nxt;
			evicted_payload_s1 <= evicted_payload_nxt;
			count_s1           <= count_nxt;
			cmd_s1             <= cmd_e'(req.command);
		end
	end

	// Capacity register, entry count and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (apply) begin
				count_q     <= count_s1;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (apply) begin
			hit_q             <= hit_s1;
			hit_index_q       <= hit_index_s1;
			hit_payload_q     <= hit_payload_s1;
			evicted_q         <= evicted_s1;
			evicted_payload_q <= evicted_payload_s1;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.hit             = hit_q;
	assign rsp.hit_index       = hit_index_q;
	assign rsp.hit_payload     = hit_payload_q;
	assign rsp.evicted         = evicted_q;
	assign rsp.evicted_payload = evicted_payload_q;
	assign rsp.entry_total     = count_q;

	`MTFKC_ASSERT(a_count_bound, VW'(count_q) <= VW'(MAX_ENTRIES), "Entry count exceeds the cell chain.")
	`MTFKC_ASSERT(a_hit_xor_evict, !(out_valid_q && hit_q && evicted_q), "Item reports both a hit and an eviction.")
	`MTFKC_ASSERT_NEXT(a_lookup_count, apply && (cmd_s1 == CMD_LOOKUP), count_q == $past(count_q), "A lookup changed the entry count.")
	`MTFKC_ASSERT_NEXT(a_one_in_flight, accept, !req.ready, "A second item was taken before the first one was applied.")

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the move-to-front key cache: directed and random items
// are checked against a predictor of the list contents. Depends on mtfkc_pkg, the
// mtfkc_req_if and mtfkc_rsp_if interfaces and the move_to_front_key_cache top level.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mtfkc_pkg::*;

	localparam int MAX_ENTRIES = 8;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int PHASE_ITEMS = 210;
	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [SET_W-1:0] key_set;
		logic             key_bold;
		logic [PAY_W-1:0] entry_payload;
		logic [IDX_W-1:0] entry_index;
	} req_item_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] hit_index;
		logic [PAY_W-1:0] hit_payload;
		logic             evicted;
		logic [PAY_W-1:0] evicted_payload;
		logic [CNT_W-1:0] entry_total;
	} rsp_item_t;

	class cache_scoreboard;
		logic [SET_W:0]   keys [MAX_ENTRIES];
		logic [PAY_W-1:0] payloads [MAX_ENTRIES];
		int unsigned      count;
		logic [CNT_W-1:0] capacity;
		rsp_item_t        pending_results[$];
		int unsigned      errors, accepted, checked, hits, evictions;

		function new();
			count = 0;
			capacity = CAP_RESET;
		endfunction

		function int unsigned effective_capacity();
			if (capacity == 0)
				return 1;
			if (capacity > MAX_ENTRIES)
				return MAX_ENTRIES;
			return capacity;
		endfunction

		function void note_request(req_item_t it);
			rsp_item_t        want;
			logic [SET_W:0]   key;
			logic [PAY_W-1:0] found;
			int unsigned      i;
			int unsigned      cap;
			want = '0;
			key = {it.key_bold, it.key_set};
			accepted++;
			case (it.command)
				CMD_LOOKUP: begin
					for (i = 0; i < count; i++) begin
						if (keys[i] == key) begin
							found = payloads[i];
							want.hit = 1'b1;
							want.hit_index = i[IDX_W-1:0];
							want.hit_payload = found;
							for (int j = i; j > 0; j--) begin
								keys[j] = keys[j-1];
								payloads[j] = payloads[j-1];
							end
							keys[0] = key;
							payloads[0] = found;
							break;
						end
					end
				end
				CMD_INSERT: begin
					cap = effective_capacity();
					if (count >= cap) begin
						want.evicted = 1'b1;
						want.evicted_payload = payloads[count-1];
						count = cap - 1;
					end
					for (i = count; i > 0; i--) begin
						keys[i] = keys[i-1];
						payloads[i] = payloads[i-1];
					end
					keys[0] = key;
					payloads[0] = it.entry_payload;
					count++;
				end
				CMD_DISCARD: begin
					if (it.entry_index < count) begin
						want.evicted = 1'b1;
						want.evicted_payload = payloads[it.entry_index];
						for (i = it.entry_index; i + 1 < count; i++) begin
							keys[i] = keys[i+1];
							payloads[i] = payloads[i+1];
						end
						count--;
					end
				end
				default: begin
				end
			endcase
			want.entry_total = count[CNT_W-1:0];
			hits += want.hit;
			evictions += want.evicted;
			pending_results.push_back(want);
		endfunction

		task report(string line);
			if (errors < PRINT_LIMIT)
				$display("mismatch at %0t: %s", $realtime, line);
			errors++;
		endtask

		task check_result(rsp_item_t got);
			rsp_item_t want;
			if (pending_results.size() == 0) begin
				report("result arrived with nothing expected");
				return;
			end
			want = pending_results.pop_front();
			checked++;
			if (got.hit !== want.hit)
				report($sformatf("result %0d hit %b, expected %b", checked, got.hit, want.hit));
			if (got.hit_index !== want.hit_index)
				report($sformatf("result %0d hit_index %0d, expected %0d", checked,
					got.hit_index, want.hit_index));
			if (got.hit_payload !== want.hit_payload)
				report($sformatf("result %0d hit_payload %h, expected %h", checked,
					got.hit_payload, want.hit_payload));
			if (got.evicted !== want.evicted)
				report($sformatf("result %0d evicted %b, expected %b", checked,
					got.evicted, want.evicted));
			if (got.evicted_payload !== want.evicted_payload)
				report($sformatf("result %0d evicted_payload %h, expected %h", checked,
					got.evicted_payload, want.evicted_payload));
			if (got.entry_total !== want.entry_total)
				report($sformatf("result %0d entry_total %0d, expected %0d", checked,
					got.entry_total, want.entry_total));
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;
	int               req_calm, rsp_calm;
	int unsigned      capacity_writes;
	cache_scoreboard  sb;

	mtfkc_req_if req_ch ();
	mtfkc_rsp_if rsp_ch ();

	move_to_front_key_cache #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#3ms;
		$display("timeout with %0d results outstanding", sb.pending_results.size());
		$display("testbench failed");
		$finish;
	end

	function automatic int unsigned draw_wait(ref int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 31) == 0)
			calm = $urandom_range(8, 48);
		return $urandom_range(0, 18);
	endfunction

	function automatic req_item_t make_item(logic [CMD_W-1:0] command, int set, bit bold,
		int payload, int index);
		req_item_t it;
		it.command = command;
		it.key_set = set[SET_W-1:0];
		it.key_bold = bold;
		it.entry_payload = payload[PAY_W-1:0];
		it.entry_index = index[IDX_W-1:0];
		return it;
	endfunction

	// Most lookups and discards aim at entries that are present, so that hits and
	// removals reach every position; keys come mostly from a small pool.
	function automatic req_item_t random_item();
		req_item_t   it;
		int unsigned roll;
		int unsigned pos;
		it = make_item(CMD_LOOKUP, $urandom_range(0, 5), 1'($urandom_range(0, 1)),
			$urandom_range(0, 65535), $urandom_range(0, 7));
		if ($urandom_range(0, 4) == 0)
			it.key_set = SET_W'($urandom_range(0, 255));
		roll = $urandom_range(0, 99);
		if (roll < 40) begin
			it.command = CMD_LOOKUP;
			if (sb.count > 0 && $urandom_range(0, 9) < 7) begin
				pos = $urandom_range(0, sb.count - 1);
				{it.key_bold, it.key_set} = sb.keys[pos];
			end
		end else if (roll < 75) begin
			it.command = CMD_INSERT;
		end else if (roll < 95) begin
			it.command = CMD_DISCARD;
			if (sb.count > 0 && $urandom_range(0, 9) < 7)
				it.entry_index = IDX_W'($urandom_range(0, sb.count - 1));
		end else begin
			it.command = CMD_UNUSED;
		end
		return it;
	endfunction

	task send_item(req_item_t it);
		int unsigned gap;
		gap = draw_wait(req_calm);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= it.command;
		req_ch.key_set <= it.key_set;
		req_ch.key_bold <= it.key_bold;
		req_ch.entry_payload <= it.entry_payload;
		req_ch.entry_index <= it.entry_index;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending_results.size() != 0);
	endtask

	task write_capacity(logic [CNT_W-1:0] value);
		drain();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.capacity = value;
		capacity_writes++;
	endtask

	initial begin
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			int unsigned stall;
			stall = draw_wait(rsp_calm);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				sb.note_request('{command: req_ch.command, key_set: req_ch.key_set,
					key_bold: req_ch.key_bold, entry_payload: req_ch.entry_payload,
					entry_index: req_ch.entry_index});
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_result('{hit: rsp_ch.hit, hit_index: rsp_ch.hit_index,
					hit_payload: rsp_ch.hit_payload, evicted: rsp_ch.evicted,
					evicted_payload: rsp_ch.evicted_payload,
					entry_total: rsp_ch.entry_total});
		end
	end

	initial begin
		logic [CNT_W-1:0] phase_caps [6];
		sb = new();
		req_calm = 0;
		rsp_calm = 0;
		capacity_writes = 0;
		phase_caps = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd5};
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.command <= CMD_LOOKUP;
		req_ch.key_set <= '0;
		req_ch.key_bold <= 1'b0;
		req_ch.entry_payload <= '0;
		req_ch.entry_index <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list, duplicate keys, misses that differ only in the bold bit,
		// and discards past the end, all at the reset capacity.
		send_item(make_item(CMD_LOOKUP, 0, 0, 0, 0));
		send_item(make_item(CMD_DISCARD, 0, 0, 0, 0));
		send_item(make_item(CMD_UNUSED, 255, 1, 'hffff, 7));
		send_item(make_item(CMD_INSERT, 0, 0, 'h0000, 0));
		send_item(make_item(CMD_INSERT, 255, 1, 'hffff, 7));
		send_item(make_item(CMD_INSERT, 255, 1, 'h1234, 0));
		send_item(make_item(CMD_INSERT, 7, 0, 'h5555, 0));
		send_item(make_item(CMD_LOOKUP, 255, 1, 0, 0));
		send_item(make_item(CMD_LOOKUP, 0, 0, 0, 0));
		send_item(make_item(CMD_LOOKUP, 42, 1, 0, 0));
		send_item(make_item(CMD_LOOKUP, 0, 1, 0, 0));
		send_item(make_item(CMD_DISCARD, 0, 0, 0, 7));
		send_item(make_item(CMD_DISCARD, 0, 0, 0, 3));
		send_item(make_item(CMD_INSERT, 128, 0, 'h8000, 0));
		send_item(make_item(CMD_INSERT, 1, 1, 'h00ff, 0));

		// Capacity lowered below the count, then the out-of-range settings.
		write_capacity(4'd2);
		send_item(make_item(CMD_INSERT, 200, 0, 'haaaa, 0));
		send_item(make_item(CMD_INSERT, 201, 1, 'h5a5a, 0));
		write_capacity(4'd0);
		send_item(make_item(CMD_INSERT, 17, 0, 'h0001, 0));
		send_item(make_item(CMD_INSERT, 17, 1, 'hfffe, 0));
		write_capacity(4'd15);
		send_item(make_item(CMD_INSERT, 99, 0, 'h7777, 0));
		send_item(make_item(CMD_LOOKUP, 17, 1, 0, 0));

		for (int phase = 0; phase < 7; phase++) begin
			if (phase < 6)
				write_capacity(phase_caps[phase]);
			else
				write_capacity(CNT_W'($urandom_range(0, 15)));
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_item(random_item());
		end

		drain();
		repeat (10) @(posedge clk);
		if (sb.pending_results.size() != 0)
			sb.report("expected results left over at the end");
		$display("covered %0d items over %0d capacity settings: %0d lookup hits, %0d removals",
			sb.accepted, capacity_writes, sb.hits, sb.evictions);
		$display("%0d results checked, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end
endmodule
